// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the interval selection RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rn, expr) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
		else $error("assertion failed: expression does not hold");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("assertion failed: implication does not hold");

`endif

// ===== rtl/core/mdis_pkg.sv =====
// Package for the maximum disjoint interval selection core.
// Holds sizes, the interval and control types and the back end state encoding.
`timescale 1ns / 1ps

package mdis_pkg;

	localparam int MAX_INTERVALS = 32;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int PT_W          = 32;
	localparam int FIFO_DEPTH    = 4;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);
	localparam int FCNT_W        = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic signed [PT_W-1:0] hi;
		logic signed [PT_W-1:0] lo;
	} span_t;

	typedef struct packed {
		logic  fin;
		span_t span;
	} queue_item_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} chain_ctl_t;

	typedef struct packed {
		span_t          head;
		logic [CNT_W-1:0] count;
		logic           full;
	} chain_sts_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_FLUSH
	} back_state_t;

endpackage

// ===== rtl/core/max_disjoint_interval_select_core.sv =====
// Top level of the greedy maximum disjoint interval selection core.
// Depends on mdis_pkg, mdis_front, mdis_back and mdis_chain.
//
// Usage: intervals arrive on the slave stream, one item per cycle while tready
// is high, with tlast marking the final interval of a set. Up to MAX_INTERVALS
// intervals are kept; further ones are dropped and every result of that set
// carries the overflow flag in tuser. The selected intervals leave on the
// master stream in ascending end order, tlast on the last one of the answer.
// Throughput: loading runs at one item per cycle while the back end is loading,
// through a four-item queue into a chain of cells that inserts in sorted order.
// After the final item the back end walks the chain, one cell per cycle unless
// the output stalls; the queue keeps taking items of the next set until full.
// Reset empties the queue and the chain and clears the overflow flag. When the
// receiver stalls, one result waits in the output register and one in a
// holding register; the walk then pauses and the queue backs up to tready.
`timescale 1ns / 1ps

module max_disjoint_interval_select_core import mdis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [2*PT_W-1:0]   s_axis_tdata,  // start_point, end_point
	input  logic                s_axis_tlast,  // final_item
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [2*PT_W-1:0]   m_axis_tdata,  // chosen_start, chosen_end
	output logic                m_axis_tlast,  // last_of_run
	output logic                m_axis_tuser   // overflowed
);

	queue_item_t in_item;
	queue_item_t q_item;
	logic        q_valid;
	logic        q_ready;
	span_t       out_span;

	assign in_item.fin  = s_axis_tlast;
	assign in_item.span = span_t'(s_axis_tdata);

	mdis_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	mdis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_span  (out_span),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser)
	);

	assign m_axis_tdata = out_span;

endmodule

// ===== rtl/core/mdis_front.sv =====
// Front end: accepts input items and queues them for the back end.
// Depends on mdis_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdis_front import mdis_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  queue_item_t  in_item,
	output logic         q_valid,
	input  logic         q_ready,
	output queue_item_t  q_item
);

	queue_item_t       entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign in_ready = fill_q != FCNT_W'(FIFO_DEPTH);
	assign q_valid  = fill_q != '0;
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FCNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FCNT_W'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FCNT_W'(FIFO_DEPTH))

endmodule

// ===== rtl/core/mdis_chain.sv =====
// Sorted interval chain: a row of cells kept in ascending end order.
// Inserts one interval per cycle in parallel, or pops the head. Depends on mdis_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdis_chain import mdis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  span_t      new_span,
	output chain_sts_t sts
);

	span_t            cell_q [MAX_INTERVALS];
	logic [CNT_W-1:0] count_q;
	logic [MAX_INTERVALS-1:0] gt;
	logic [MAX_INTERVALS-1:0] mark;

	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		assign gt[i]   = (CNT_W'(i) < count_q) && ($signed(cell_q[i].hi) > $signed(new_span.hi));
		assign mark[i] = gt[i] || (CNT_W'(i) == count_q);

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (ctl.ins) begin
					if (mark[i]) begin
						cell_q[i] <= new_span;
					end
				end else if (ctl.pop) begin
					if (MAX_INTERVALS > 1) begin
						cell_q[i] <= cell_q[(i + 1) % MAX_INTERVALS];
					end
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (ctl.ins) begin
					if (mark[i-1]) begin
						cell_q[i] <= cell_q[i-1];
					end else if (mark[i]) begin
						cell_q[i] <= new_span;
					end
				end else if (ctl.pop) begin
					if (i < MAX_INTERVALS - 1) begin
						cell_q[i] <= cell_q[(i + 1) % MAX_INTERVALS];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign sts.head  = cell_q[0];
	assign sts.count = count_q;
	assign sts.full  = count_q == CNT_W'(MAX_INTERVALS);

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_INTERVALS))
	`ASSERT_IMPL(a_no_ins_full, clk, arst_n, ctl.ins, !sts.full && !ctl.pop)

endmodule

// ===== rtl/core/mdis_back.sv =====
// Back end: drains the queue into the sorted chain, then walks the chain and
// emits the greedy disjoint selection. Depends on mdis_pkg and mdis_chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdis_back import mdis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  queue_item_t q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output span_t       out_span,
	output logic        out_last,
	output logic        out_ovf
);

	back_state_t     state_q;
	back_state_t     state_d;
	chain_ctl_t      ctl;
	chain_sts_t      sts;
	logic            ovf_seen_q;
	logic            ovf_run_q;
	logic            first_q;
	logic signed [PT_W-1:0] last_end_q;
	span_t           pend_q;
	logic            pend_valid_q;
	logic            out_valid_q;
	span_t           out_span_q;
	logic            out_last_q;
	logic            out_ovf_q;
	logic            out_free;
	logic            take;
	logic            chosen;
	logic            advance;
	logic            push_mid;
	logic            push_end;

	mdis_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.new_span (q_item.span),
		.sts      (sts)
	);

	assign out_free = !out_valid_q || out_ready;
	assign chosen   = first_q || ($signed(sts.head.lo) > last_end_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (q_valid && q_item.fin) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.count == '0) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		q_ready  = 1'b0;
		take     = 1'b0;
		advance  = 1'b0;
		push_mid = 1'b0;
		push_end = 1'b0;
		ctl      = '0;
		unique case (state_q)
			ST_LOAD: begin
				q_ready = 1'b1;
				take    = q_valid;
				ctl.ins = q_valid && !sts.full;
			end
			ST_WALK: begin
				if (sts.count != '0) begin
					advance  = !chosen || !pend_valid_q || out_free;
					push_mid = advance && chosen && pend_valid_q;
					ctl.pop  = advance;
				end
			end
			ST_FLUSH: begin
				push_end = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			ovf_seen_q   <= 1'b0;
			ovf_run_q    <= 1'b0;
			first_q      <= 1'b1;
			last_end_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (q_item.fin) begin
					ovf_run_q  <= ovf_seen_q || sts.full;
					ovf_seen_q <= 1'b0;
					first_q    <= 1'b1;
				end else if (sts.full) begin
					ovf_seen_q <= 1'b1;
				end
			end
			if (advance && chosen) begin
				last_end_q   <= sts.head.hi;
				first_q      <= 1'b0;
				pend_valid_q <= 1'b1;
			end else if (push_end) begin
				pend_valid_q <= 1'b0;
			end
			if (push_mid || push_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && chosen) begin
			pend_q <= sts.head;
		end
		if (push_mid || push_end) begin
			out_span_q <= pend_q;
			out_last_q <= push_end;
			out_ovf_q  <= ovf_run_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_span  = out_span_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

	`ASSERT_IMPL(a_load_no_pend, clk, arst_n, state_q == ST_LOAD, !pend_valid_q)
	`ASSERT_IMPL(a_flush_has_pend, clk, arst_n, state_q == ST_FLUSH, pend_valid_q)
	`ASSERT_IMPL(a_push_room, clk, arst_n, push_mid || push_end, out_free)

endmodule

// ===== tb/sv/tb_max_disjoint_interval_select_core.sv =====
// Self-checking testbench for max_disjoint_interval_select_core.
// Holds its own model of the greedy earliest-finish selection and checks every result item.
// Depends on mdis_pkg and the core; it needs no other file.
`timescale 1ns / 1ps

module tb_max_disjoint_interval_select_core;
	import mdis_pkg::*;

	localparam logic signed [PT_W-1:0] PT_MIN  = 32'sh8000_0000;
	localparam logic signed [PT_W-1:0] PT_MAX  = 32'sh7FFF_FFFF;
	localparam int                     PROBE_N = 20;

	typedef struct packed {
		logic signed [PT_W-1:0] lo;
		logic signed [PT_W-1:0] hi;
		logic                   last;
		logic                   ovf;
	} pick_t;

	typedef struct packed {
		logic signed [PT_W-1:0] lo;
		logic signed [PT_W-1:0] hi;
		logic                   fin;
		logic                   typed;
		logic signed [PT_W-1:0] w_lo;
		logic signed [PT_W-1:0] w_hi;
		logic                   w_last;
		logic                   w_ovf;
	} probe_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [2*PT_W-1:0] s_axis_tdata;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [2*PT_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic              m_axis_tuser;

	// Model state: the end-ordered chain and the selection bookkeeping.
	span_t                  chain [MAX_INTERVALS];
	int                     held;
	logic                   dropped;
	logic signed [PT_W-1:0] last_end;
	pick_t                  picks_due [$];

	int unsigned            mismatches;
	int unsigned            results_seen;
	int unsigned            send_calm;
	int unsigned            sink_calm;
	int unsigned            sink_wait;
	logic                   hold_off;
	logic signed [PT_W-1:0] gen_base;
	logic signed [PT_W-1:0] gen_last_hi;
	pick_t                  want_now;

	probe_row_t probes [PROBE_N] = '{
		'{PT_MIN, PT_MAX, 1'b1, 1'b1, PT_MIN, PT_MAX, 1'b1, 1'b0},
		'{PT_MAX, PT_MIN, 1'b1, 1'b1, PT_MAX, PT_MIN, 1'b1, 1'b0},
		'{32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0, 1'b1, 1'b0},
		'{-32'sd1, -32'sd1, 1'b1, 1'b1, -32'sd1, -32'sd1, 1'b1, 1'b0},
		'{32'sd0, 32'sd10, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd10, 32'sd20, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd11, 32'sd30, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd31, 32'sd31, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd5, 32'sd50, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd1, 32'sd50, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{-32'sd3, -32'sd1, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd51, 32'sd60, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd100, 32'sd90, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd80, 32'sd95, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd91, 32'sd200, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{PT_MIN, PT_MIN, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{PT_MAX, PT_MAX, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sd0, PT_MAX, 1'b1, 1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0},
		'{32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 1'b1,
			32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 1'b0},
		'{32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, 1'b1,
			32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, 1'b0}
	};

	max_disjoint_interval_select_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Inserts one interval into the end-ordered chain and, on the final item of a set,
	// walks the chain and, when queue_picks is set, queues the chosen intervals.
	task automatic load_interval(input logic signed [PT_W-1:0] lo, input logic signed [PT_W-1:0] hi,
			input logic fin, input logic queue_picks);
		int    pos;
		int    i;
		int    n;
		pick_t p;
		if (held < MAX_INTERVALS) begin
			pos = held;
			while (pos > 0 && chain[pos-1].hi > hi) begin
				chain[pos] = chain[pos-1];
				pos--;
			end
			chain[pos].lo = lo;
			chain[pos].hi = hi;
			held++;
		end else begin
			dropped = 1'b1;
		end
		if (fin) begin
			n = 0;
			for (i = 0; i < held; i++) begin
				if (n == 0 || chain[i].lo > last_end) begin
					last_end = chain[i].hi;
					p.lo     = chain[i].lo;
					p.hi     = chain[i].hi;
					p.last   = 1'b0;
					p.ovf    = dropped;
					if (queue_picks)
						picks_due.push_back(p);
					n++;
				end
			end
			if (queue_picks && n > 0)
				picks_due[picks_due.size()-1].last = 1'b1;
			held    = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic send_item(input logic signed [PT_W-1:0] lo, input logic signed [PT_W-1:0] hi,
			input logic fin, input logic typed, input pick_t want);
		int unsigned gap;
		s_axis_tdata  <= {hi, lo};
		s_axis_tlast  <= fin;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		load_interval(lo, hi, fin, !typed);
		if (typed)
			picks_due.push_back(want);
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly clustered intervals so that overlaps, touching bounds and shared ends are common.
	task automatic make_span(output logic signed [PT_W-1:0] lo, output logic signed [PT_W-1:0] hi);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			lo = gen_base + $urandom_range(0, 200);
			hi = lo + $urandom_range(0, 40);
		end else if (r < 65) begin
			lo = gen_last_hi;
			hi = lo + $urandom_range(0, 30);
		end else if (r < 77) begin
			hi = gen_last_hi;
			lo = hi - $urandom_range(0, 30);
		end else if (r < 88) begin
			lo = gen_base + $urandom_range(0, 200);
			hi = lo - $urandom_range(1, 50);
		end else begin
			lo = $urandom;
			hi = $urandom;
		end
		gen_last_hi = hi;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (picks_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: start %0d end %0d last %0b overflow %0b",
						$signed(m_axis_tdata[PT_W-1:0]), $signed(m_axis_tdata[2*PT_W-1:PT_W]),
						m_axis_tlast, m_axis_tuser);
			end else begin
				want_now = picks_due.pop_front();
				if (m_axis_tdata[PT_W-1:0] !== want_now.lo
						|| m_axis_tdata[2*PT_W-1:PT_W] !== want_now.hi
						|| m_axis_tlast !== want_now.last || m_axis_tuser !== want_now.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
							want_now.lo, want_now.hi, want_now.last, want_now.ovf,
							$signed(m_axis_tdata[PT_W-1:0]),
							$signed(m_axis_tdata[2*PT_W-1:PT_W]), m_axis_tlast, m_axis_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off) begin
			m_axis_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			sink_wait = pick_gap(sink_calm);
		end
	end

	// One long stall of the receiver while the sender keeps offering items.
	initial begin
		wait (results_seen >= 5);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int    k;
		int    size;
		int    sent;
		int    set_no;
		int    r;
		logic signed [PT_W-1:0] lo;
		logic signed [PT_W-1:0] hi;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		hold_off      = 1'b0;
		sink_wait     = 0;
		sink_calm     = 0;
		send_calm     = 0;
		mismatches    = 0;
		results_seen  = 0;
		held          = 0;
		dropped       = 1'b0;
		last_end      = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < PROBE_N; k++)
			send_item(probes[k].lo, probes[k].hi, probes[k].fin, probes[k].typed,
				'{probes[k].w_lo, probes[k].w_hi, probes[k].w_last, probes[k].w_ovf});

		// The first sets fill the store exactly, lose the final item, and lose several items.
		sent   = 0;
		set_no = 0;
		while (sent + PROBE_N < 160) begin
			if (set_no == 0)
				size = MAX_INTERVALS;
			else if (set_no == 1)
				size = MAX_INTERVALS + 1;
			else if (set_no == 2)
				size = MAX_INTERVALS + 3;
			else if ($urandom_range(0, 19) == 0)
				size = $urandom_range(MAX_INTERVALS - 2, MAX_INTERVALS + 4);
			else
				size = $urandom_range(1, 8);
			r = $urandom_range(0, 99);
			if (r < 70)
				gen_base = $urandom_range(0, 2000) - 1000;
			else if (r < 88)
				gen_base = $urandom;
			else if (r < 94)
				gen_base = PT_MAX - 150;
			else
				gen_base = PT_MIN;
			gen_last_hi = gen_base;
			for (k = 0; k < size; k++) begin
				make_span(lo, hi);
				send_item(lo, hi, k == size - 1, 1'b0, '0);
			end
			sent += size;
			set_no++;
		end
		s_axis_tvalid <= 1'b0;

		while (picks_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
